// File: sv/cmfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmfs_pkg: shared definitions for the chat message field splitter
// Phase codes, field tags, register indexes and the step interface types.
// ----------------------------------------------------------------------------
package cmfs_pkg;

  localparam int MAX_MESSAGE = 512;
  localparam int CNT_W = ($clog2(MAX_MESSAGE + 1) > 10) ? $clog2(MAX_MESSAGE + 1) : 10;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] FLD_PREFIX   = 2'd0;
  localparam logic [1:0] FLD_COMMAND  = 2'd1;
  localparam logic [1:0] FLD_PARAMS   = 2'd2;
  localparam logic [1:0] FLD_TRAILING = 2'd3;

  localparam logic [1:0] REG_PREFIX_MAX   = 2'd0;
  localparam logic [1:0] REG_COMMAND_MAX  = 2'd1;
  localparam logic [1:0] REG_PARAMS_MAX   = 2'd2;
  localparam logic [1:0] REG_TRAILING_MAX = 2'd3;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_PREFIX  = 4'd1,
    PH_SKIP1   = 4'd2,
    PH_COMMAND = 4'd3,
    PH_SKIP2   = 4'd4,
    PH_COLON2  = 4'd5,
    PH_PARAMS  = 4'd6,
    PH_SKIP3   = 4'd7,
    PH_TDECIDE = 4'd8,
    PH_TALL    = 4'd9,
    PH_TWORD   = 4'd10,
    PH_SKIP4   = 4'd11,
    PH_COLON4  = 4'd12,
    PH_DONE    = 4'd13
  } phase_t;

  typedef logic [CNT_W-1:0] cons_t;

  typedef struct packed {
    logic [9:0] prefix_max;
    logic [9:0] command_max;
    logic [9:0] params_max;
    logic [9:0] trailing_max;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [9:0] field_count;
    cons_t      consumed_count;
    logic       keep;
    logic [1:0] field;
  } step_t;

endpackage

`default_nettype wire

// File: sv/cmfs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmfs_step: one parser step
// Resolves the whole chain of phase fall-throughs for one byte at once.
// ----------------------------------------------------------------------------
module cmfs_step (
  input  var cmfs_pkg::phase_t phase,
  input  var logic [9:0]       field_count,
  input  var cmfs_pkg::cons_t  consumed_count,
  input  var cmfs_pkg::cfg_t   cfg,
  input  var logic [7:0]       data_byte,
  output cmfs_pkg::step_t      step
);
  import cmfs_pkg::*;

  logic        is_space;
  logic        is_colon;
  logic [9:0]  entry_lim;
  logic        entry_lt;
  logic [12:0] stop;
  logic [3:0]  sel_idx;
  phase_t      sel;
  logic [9:0]  base;
  logic        consume;

  function automatic logic room(input phase_t ph, input phase_t entry, input logic lt,
                                input logic [9:0] lim);
    room = (ph == entry) ? lt : (lim != 10'd0);
  endfunction

  always_comb begin
    is_space = (data_byte == CH_SPACE);
    is_colon = (data_byte == CH_COLON);
    unique case (phase)
      PH_PREFIX:  entry_lim = cfg.prefix_max;
      PH_COMMAND: entry_lim = cfg.command_max;
      PH_PARAMS:  entry_lim = cfg.params_max;
      default:    entry_lim = cfg.trailing_max;
    endcase
    entry_lt = (field_count < entry_lim);

    stop = '0;
    stop[PH_START]   = is_colon;
    stop[PH_PREFIX]  = room(PH_PREFIX, phase, entry_lt, cfg.prefix_max) && !is_space;
    stop[PH_SKIP1]   = is_space;
    stop[PH_COMMAND] = room(PH_COMMAND, phase, entry_lt, cfg.command_max) && !is_space;
    stop[PH_SKIP2]   = is_space;
    stop[PH_COLON2]  = is_colon;
    stop[PH_PARAMS]  = room(PH_PARAMS, phase, entry_lt, cfg.params_max) && !is_space;
    stop[PH_SKIP3]   = is_space;
    stop[PH_TDECIDE] = is_colon;
    stop[PH_TALL]    = (phase == PH_TALL);
    stop[PH_TWORD]   = room(PH_TWORD, phase, entry_lt, cfg.trailing_max) && !is_space;
    stop[PH_SKIP4]   = is_space;
    stop[PH_COLON4]  = 1'b1;

    sel_idx = PH_DONE;
    for (int k = 12; k >= 0; k--) begin
      if (stop[k] && (4'(k) >= phase)) begin
        sel_idx = 4'(k);
      end
    end
    if (data_byte == CH_NUL || phase > PH_COLON4) begin
      sel_idx = PH_DONE;
    end
    sel = phase_t'(sel_idx);

    base = (sel == phase) ? field_count : 10'd0;

    step.phase       = sel;
    step.field_count = 10'd0;
    step.keep        = 1'b0;
    step.field       = FLD_PREFIX;
    consume          = 1'b1;
    unique case (sel) inside
      PH_START: begin
        step.phase = PH_PREFIX;
      end
      PH_PREFIX: begin
        step.keep        = 1'b1;
        step.field       = FLD_PREFIX;
        step.field_count = base + 10'd1;
      end
      PH_COMMAND: begin
        step.keep        = 1'b1;
        step.field       = FLD_COMMAND;
        step.field_count = base + 10'd1;
      end
      PH_PARAMS: begin
        step.keep        = 1'b1;
        step.field       = FLD_PARAMS;
        step.field_count = base + 10'd1;
      end
      PH_TWORD: begin
        step.keep        = 1'b1;
        step.field       = FLD_TRAILING;
        step.field_count = base + 10'd1;
      end
      PH_SKIP1, PH_SKIP2, PH_SKIP3, PH_SKIP4: begin
      end
      PH_COLON2: begin
        step.phase = PH_PARAMS;
      end
      PH_TDECIDE: begin
        step.phase = PH_TALL;
      end
      PH_COLON4: begin
        step.phase = PH_DONE;
        consume    = is_colon;
      end
      PH_TALL: begin
        if (entry_lt) begin
          step.keep        = 1'b1;
          step.field       = FLD_TRAILING;
          step.field_count = field_count + 10'd1;
        end else begin
          step.phase = PH_DONE;
          consume    = 1'b0;
        end
      end
      default: begin
        step.phase = PH_DONE;
        consume    = 1'b0;
      end
    endcase

    if (consume && consumed_count < CNT_W'(MAX_MESSAGE)) begin
      step.consumed_count = consumed_count + CNT_W'(1);
    end else begin
      step.consumed_count = consumed_count;
    end
  end

endmodule

`default_nettype wire

// File: sv/chat_message_field_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chat_message_field_splitter: streaming field splitter for chat protocol lines
// Tags each kept byte of a line as prefix, command, params or trailing.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle while stall is low, and its result, if it has
// one, appears on the output register in the next cycle, or in the skid register
// if the output is stalled. The parse state advances within the same cycle as the
// byte is accepted, so one byte per cycle is sustained while stall is low. The
// one-entry skid register absorbs one result; the input is stalled only while it
// is occupied. Configuration writes take effect at the next cycle.
module chat_message_field_splitter (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       cfg_write,
  input  var logic [1:0] cfg_index,
  input  var logic [9:0] cfg_data,
  input  var logic       valid,
  output logic           stall,
  input  var logic [7:0] data_byte,
  input  var logic       last,
  output logic           result_valid,
  input  var logic       result_stall,
  output logic [7:0]     out_byte,
  output logic [1:0]     field,
  output logic           byte_valid,
  output logic           message_end,
  output logic [9:0]     consumed
);
  import cmfs_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] field;
    logic       byte_valid;
    logic       message_end;
    logic [9:0] consumed;
  } res_t;

  cfg_t       cfg;
  phase_t     phase;
  logic [9:0] field_count;
  cons_t      consumed_count;
  step_t      step;
  logic       accept;
  logic       push;
  res_t       res_next;
  res_t       out_res;
  res_t       skid_res;
  logic       skid_valid;
  logic       load_out;

  cmfs_step u_step (
    .phase          (phase),
    .field_count    (field_count),
    .consumed_count (consumed_count),
    .cfg            (cfg),
    .data_byte      (data_byte),
    .step           (step)
  );

  assign stall    = skid_valid;
  assign accept   = valid && !skid_valid;
  assign push     = accept && (step.keep || last);
  assign load_out = !result_valid || !result_stall;

  always_comb begin
    res_next.out_byte    = step.keep ? data_byte : 8'd0;
    res_next.field       = step.keep ? step.field : FLD_PREFIX;
    res_next.byte_valid  = step.keep;
    res_next.message_end = last;
    res_next.consumed    = last ? step.consumed_count[9:0] : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefix_max   <= 10'd128;
      cfg.command_max  <= 10'd16;
      cfg.params_max   <= 10'd64;
      cfg.trailing_max <= 10'd512;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PREFIX_MAX:   cfg.prefix_max   <= cfg_data;
        REG_COMMAND_MAX:  cfg.command_max  <= cfg_data;
        REG_PARAMS_MAX:   cfg.params_max   <= cfg_data;
        REG_TRAILING_MAX: cfg.trailing_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      field_count    <= 10'd0;
      consumed_count <= '0;
    end else if (accept) begin
      if (last) begin
        phase          <= PH_START;
        field_count    <= 10'd0;
        consumed_count <= '0;
      end else begin
        phase          <= step.phase;
        field_count    <= step.field_count;
        consumed_count <= step.consumed_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= res_next;
      end
    end else if (push) begin
      skid_res <= res_next;
    end
  end

  assign out_byte    = out_res.out_byte;
  assign field       = out_res.field;
  assign byte_valid  = out_res.byte_valid;
  assign message_end = out_res.message_end;
  assign consumed    = out_res.consumed;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register holds a request while the output is empty");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (phase == PH_START && consumed_count == '0 && field_count == 10'd0))
    else $error("line state not cleared after the final byte");

  a_consumed_sat: assert property (@(posedge clk) disable iff (rst)
    consumed_count <= CNT_W'(MAX_MESSAGE))
    else $error("consumed count exceeds the message limit");

  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (byte_valid || message_end))
    else $error("result carries neither a kept byte nor a line end");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && push) |=> skid_valid)
    else $error("request lost while the output was stalled");

endmodule

`default_nettype wire

// File: tb/tb_chat_message_field_splitter.sv
// ----------------------------------------------------------------------------
// tb_chat_message_field_splitter: self-checking bench for the field splitter
// Sends protocol lines one byte per request, with random source gaps and
// random sink stalls. A behavioural predictor of the splitter works out each
// expected result, except where a directed row gives its own, and every result
// is compared with it field by field. The run covers a directed table and then
// random lines under several sets of field limits.
// ----------------------------------------------------------------------------
module tb_chat_message_field_splitter;
  import cmfs_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] field;
    logic       byte_valid;
    logic       message_end;
    logic [9:0] consumed;
  } split_result_t;

  typedef struct packed {
    logic [7:0]    data_byte;
    logic          last;
    logic          typed;
    split_result_t result;
  } stim_row_t;

  localparam split_result_t UNTYPED = '0;
  localparam int ROWS = 26;
  localparam int PHASE_ITEMS = 140;
  localparam int SETTLE = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_PREFIX_MAX;
  logic [9:0] cfg_data = '0;
  logic       valid = 1'b0;
  logic       stall;
  logic [7:0] data_byte = '0;
  logic       last = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] field;
  logic       byte_valid;
  logic       message_end;
  logic [9:0] consumed;

  logic [9:0]    limit_reg [4];
  phase_t        line_phase;
  logic [9:0]    line_count;
  cons_t         line_consumed;
  split_result_t expected_q [$];
  logic [7:0]    line_bytes [$];
  stim_row_t     directed_rows [ROWS];

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int lines_sent = 0;
  int stall_left = 0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  chat_message_field_splitter dut (
    .clk,
    .rst,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .valid,
    .stall,
    .data_byte,
    .last,
    .result_valid,
    .result_stall,
    .out_byte,
    .field,
    .byte_valid,
    .message_end,
    .consumed
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_line();
    line_phase = PH_START;
    line_count = '0;
    line_consumed = '0;
  endfunction

  function automatic void bump_consumed();
    if (line_consumed < MAX_MESSAGE) line_consumed++;
  endfunction

  function automatic bit split_byte(input logic [7:0] b, input logic lst,
                                    output split_result_t r);
    logic       kept;
    logic       settled;
    logic [1:0] tag;
    logic [9:0] lim;
    int         guard;
    kept = 1'b0;
    settled = 1'b0;
    tag = FLD_PREFIX;
    lim = '0;
    if (b == CH_NUL) line_phase = PH_DONE;
    for (guard = 0; guard < 16 && !settled; guard++) begin
      case (line_phase)
        PH_START: begin
          line_phase = PH_PREFIX;
          line_count = '0;
          if (b == CH_COLON) begin
            bump_consumed();
            settled = 1'b1;
          end
        end
        PH_PREFIX, PH_COMMAND, PH_PARAMS, PH_TWORD: begin
          case (line_phase)
            PH_PREFIX: begin lim = limit_reg[REG_PREFIX_MAX]; tag = FLD_PREFIX; end
            PH_COMMAND: begin lim = limit_reg[REG_COMMAND_MAX]; tag = FLD_COMMAND; end
            PH_PARAMS: begin lim = limit_reg[REG_PARAMS_MAX]; tag = FLD_PARAMS; end
            default: begin lim = limit_reg[REG_TRAILING_MAX]; tag = FLD_TRAILING; end
          endcase
          if (line_count < lim && b != CH_SPACE) begin
            kept = 1'b1;
            line_count++;
            bump_consumed();
            settled = 1'b1;
          end else begin
            line_phase = phase_t'(line_phase + 1);
          end
        end
        PH_SKIP1, PH_SKIP2, PH_SKIP3, PH_SKIP4: begin
          if (b == CH_SPACE) begin
            bump_consumed();
            settled = 1'b1;
          end else begin
            line_phase = phase_t'(line_phase + 1);
            line_count = '0;
          end
        end
        PH_COLON2: begin
          line_phase = PH_PARAMS;
          line_count = '0;
          if (b == CH_COLON) begin
            bump_consumed();
            settled = 1'b1;
          end
        end
        PH_TDECIDE: begin
          line_count = '0;
          if (b == CH_COLON) begin
            line_phase = PH_TALL;
            bump_consumed();
            settled = 1'b1;
          end else begin
            line_phase = PH_TWORD;
          end
        end
        PH_TALL: begin
          if (line_count < limit_reg[REG_TRAILING_MAX]) begin
            kept = 1'b1;
            tag = FLD_TRAILING;
            line_count++;
            bump_consumed();
            settled = 1'b1;
          end else begin
            line_phase = PH_DONE;
          end
        end
        PH_COLON4: begin
          line_phase = PH_DONE;
          if (b == CH_COLON) bump_consumed();
          settled = 1'b1;
        end
        default: begin
          line_phase = PH_DONE;
          settled = 1'b1;
        end
      endcase
    end
    r.out_byte = kept ? b : 8'h00;
    r.field = kept ? tag : FLD_PREFIX;
    r.byte_valid = kept;
    r.message_end = lst;
    r.consumed = lst ? line_consumed[9:0] : 10'd0;
    if (lst) clear_line();
    return kept || lst;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 100) begin
      $display("Mismatch on %s in result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    end
  endtask

  task automatic check_result();
    split_result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch("a result with nothing expected, out_byte", out_byte, 0);
      return;
    end
    want = expected_q.pop_front();
    if (out_byte !== want.out_byte) report_mismatch("out_byte", out_byte, want.out_byte);
    if (field !== want.field) report_mismatch("field", field, want.field);
    if (byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", byte_valid, want.byte_valid);
    if (message_end !== want.message_end)
      report_mismatch("message_end", message_end, want.message_end);
    if (consumed !== want.consumed) report_mismatch("consumed", consumed, want.consumed);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_result();
      stall_left = sink_quiet ? 0 : $urandom_range(0, 12);
    end
    if ($urandom_range(0, 199) == 0) sink_quiet = !sink_quiet;
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input split_result_t typed_r);
    int            gap;
    split_result_t r;
    gap = src_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    data_byte <= b;
    last <= lst;
    @(posedge clk);
    while (stall) @(posedge clk);
    items_sent++;
    if (split_byte(b, lst, r)) expected_q.push_back(typed ? typed_r : r);
  endtask

  task automatic send_line();
    if ($urandom_range(0, 5) == 0) src_quiet = !src_quiet;
    foreach (line_bytes[i]) begin
      send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, UNTYPED);
    end
    lines_sent++;
  endtask

  task automatic drain();
    valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_limits(input logic [9:0] pfx, input logic [9:0] cmd,
                                input logic [9:0] prm, input logic [9:0] trl);
    logic [9:0] v [4];
    int         i;
    v[REG_PREFIX_MAX] = pfx;
    v[REG_COMMAND_MAX] = cmd;
    v[REG_PARAMS_MAX] = prm;
    v[REG_TRAILING_MAX] = trl;
    for (i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= v[i];
      limit_reg[i] = v[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 254));
    if (c >= CH_SPACE) c = c + 8'd1;
    return c;
  endfunction

  function automatic void add_word(input int len);
    repeat (len) line_bytes.push_back(word_char());
  endfunction

  function automatic void add_spaces(input int n);
    repeat (n) line_bytes.push_back(CH_SPACE);
  endfunction

  function automatic int word_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
  endfunction

  function automatic void make_line();
    int n;
    line_bytes.delete();
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2: line_bytes.push_back(CH_SPACE);
          3, 4: line_bytes.push_back(CH_COLON);
          5: line_bytes.push_back(CH_NUL);
          default: line_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(0, 1) == 1) line_bytes.push_back(CH_COLON);
      add_word(word_len());
      add_spaces($urandom_range(1, 3));
      add_word(word_len());
      add_spaces($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 1) line_bytes.push_back(CH_COLON);
      add_word(word_len());
      add_spaces($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0: begin
          line_bytes.push_back(CH_COLON);
          repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(1, 255)));
        end
        1: begin
          add_word(word_len());
          add_spaces($urandom_range(0, 2));
          if ($urandom_range(0, 1) == 1) line_bytes.push_back(CH_COLON);
          repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom_range(1, 255)));
        end
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) begin
        line_bytes[$urandom_range(0, line_bytes.size() - 1)] = CH_NUL;
      end
    end
  endfunction

  initial begin
    int p;
    int phase_start;
    limit_reg[REG_PREFIX_MAX] = 10'd128;
    limit_reg[REG_COMMAND_MAX] = 10'd16;
    limit_reg[REG_PARAMS_MAX] = 10'd64;
    limit_reg[REG_TRAILING_MAX] = 10'd512;
    clear_line();
    directed_rows = '{
      '{CH_NUL, 1'b1, 1'b1, '{8'h00, FLD_PREFIX, 1'b0, 1'b1, 10'd0}},
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, FLD_PREFIX, 1'b1, 1'b1, 10'd1}},
      '{8'h01, 1'b1, 1'b1, '{8'h01, FLD_PREFIX, 1'b1, 1'b1, 10'd1}},
      '{CH_COLON, 1'b1, 1'b1, '{8'h00, FLD_PREFIX, 1'b0, 1'b1, 10'd1}},
      '{CH_COLON, 1'b0, 1'b0, UNTYPED},
      '{"p", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{"C", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{CH_COLON, 1'b0, 1'b0, UNTYPED},
      '{"x", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{CH_COLON, 1'b0, 1'b0, UNTYPED},
      '{"t", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{"t", 1'b1, 1'b0, UNTYPED},
      '{"a", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{"b", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{"c", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{"w", 1'b0, 1'b0, UNTYPED},
      '{CH_SPACE, 1'b0, 1'b0, UNTYPED},
      '{CH_COLON, 1'b0, 1'b0, UNTYPED},
      '{"z", 1'b1, 1'b0, UNTYPED}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data_byte, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].result);
    end
    for (p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: program_limits(10'd0, 10'd0, 10'd0, 10'd0);
        1: program_limits(10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                          10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)));
        2: program_limits(10'd512, 10'd512, 10'd512, 10'd512);
        3: program_limits(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        4: program_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                          10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        5: program_limits(10'($urandom_range(0, 10)), 10'($urandom_range(0, 10)),
                          10'($urandom_range(0, 10)), 10'($urandom_range(0, 10)));
        6: program_limits(10'd0, 10'($urandom_range(1, 3)), 10'($urandom_range(0, 4)),
                          10'd1023);
        default: program_limits(10'd128, 10'd16, 10'd64, 10'd512);
      endcase
      phase_start = items_sent;
      if (p == 3) begin
        // A long trailing part drives the consumed count into saturation.
        line_bytes = '{CH_COLON, "x", CH_SPACE, "c", CH_SPACE, "p", CH_SPACE, CH_COLON};
        repeat (560) line_bytes.push_back(8'($urandom_range(1, 255)));
        send_line();
      end
      while (items_sent - phase_start < PHASE_ITEMS) begin
        make_line();
        send_line();
      end
    end
    drain();
    $display("Sent %0d lines (%0d bytes) under 9 limit sets and checked %0d results.",
             lines_sent, items_sent, results_seen);
    $display("Mismatches recorded: %0d.", errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
